// ===== rtl/core/cau_pkg.sv =====
// Package for the complex arithmetic unit: widths, command codes, pipeline
// depths and the saturation helpers. No dependencies.

package cau_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = SUM_W - 1;
    localparam int NUM_W  = MAG_W + FRAC_W;
    localparam int DEN_W  = PROD_W;
    localparam int QUO_W  = DATA_W;
    localparam int CMP_W  = DEN_W + QUO_W + 1;
    localparam int DIV_LAT  = QUO_W + 1;
    localparam int PIPE_LAT = DIV_LAT + 4;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_ADD = 2'd0;
    localparam cmd_t CMD_SUB = 2'd1;
    localparam cmd_t CMD_MUL = 2'd2;
    localparam cmd_t CMD_DIV = 2'd3;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } sat_t;

    function automatic sat_t sat_sum(input logic signed [SUM_W-1:0] x);
        sat_t r;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'($signed(SAT_MAX));
        lo = SUM_W'($signed(SAT_MIN));
        if (x > hi)
        begin
            r.val = SAT_MAX;
            r.ovf = 1'b1;
        end
        else if (x < lo)
        begin
            r.val = SAT_MIN;
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = x[DATA_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic sat_t sat_quo(input logic [QUO_W-1:0] q, input logic neg,
                                     input logic big);
        sat_t r;
        if (!neg && (big || q > SAT_MAX))
        begin
            r.val = SAT_MAX;
            r.ovf = 1'b1;
        end
        else if (neg && (big || q > SAT_MIN))
        begin
            r.val = SAT_MIN;
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = neg ? (~q + 1'b1) : q;
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/cau_mult.sv =====
// Front end of the complex arithmetic unit: input register, product stage and
// sum stage. Depends on cau_pkg.

module cau_mult
    import cau_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  cmd_t                    cmd,
    input  logic signed [DATA_W-1:0] a_real,
    input  logic signed [DATA_W-1:0] a_imag,
    input  logic signed [DATA_W-1:0] b_real,
    input  logic signed [DATA_W-1:0] b_imag,
    output logic                    out_valid,
    output cmd_t                    out_cmd,
    output logic signed [SUM_W-1:0] val_re,
    output logic signed [SUM_W-1:0] val_im,
    output logic [DEN_W-1:0]        den
);

    logic                     v1_reg, v2_reg, v3_reg;
    cmd_t                     cmd1_reg, cmd2_reg, cmd3_reg;
    logic signed [DATA_W-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PROD_W-1:0] q_rr_reg, q_ii_reg;
    logic signed [DATA_W:0]   as_re_reg, as_im_reg;
    logic signed [SUM_W-1:0]  re_reg, im_reg, re_next, im_next;
    logic [DEN_W-1:0]         den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg <= cmd;
        ar_reg   <= a_real;
        ai_reg   <= a_imag;
        br_reg   <= b_real;
        bi_reg   <= b_imag;

        cmd2_reg <= cmd1_reg;
        p_rr_reg <= ar_reg * br_reg;
        p_ii_reg <= ai_reg * bi_reg;
        p_ri_reg <= ar_reg * bi_reg;
        p_ir_reg <= ai_reg * br_reg;
        q_rr_reg <= br_reg * br_reg;
        q_ii_reg <= bi_reg * bi_reg;
        if (cmd1_reg == CMD_SUB)
        begin
            as_re_reg <= (DATA_W+1)'(ar_reg) - (DATA_W+1)'(br_reg);
            as_im_reg <= (DATA_W+1)'(ai_reg) - (DATA_W+1)'(bi_reg);
        end
        else
        begin
            as_re_reg <= (DATA_W+1)'(ar_reg) + (DATA_W+1)'(br_reg);
            as_im_reg <= (DATA_W+1)'(ai_reg) + (DATA_W+1)'(bi_reg);
        end

        cmd3_reg <= cmd2_reg;
        re_reg   <= re_next;
        im_reg   <= im_next;
        den_reg  <= DEN_W'(unsigned'(q_rr_reg)) + DEN_W'(unsigned'(q_ii_reg));
    end

    always_comb
    begin
        unique case (cmd2_reg)
            CMD_ADD, CMD_SUB:
            begin
                re_next = SUM_W'(as_re_reg);
                im_next = SUM_W'(as_im_reg);
            end
            CMD_MUL:
            begin
                re_next = SUM_W'(p_rr_reg) - SUM_W'(p_ii_reg);
                im_next = SUM_W'(p_ri_reg) + SUM_W'(p_ir_reg);
            end
            default:
            begin
                re_next = SUM_W'(p_rr_reg) + SUM_W'(p_ii_reg);
                im_next = SUM_W'(p_ir_reg) - SUM_W'(p_ri_reg);
            end
        endcase
    end

    assign out_valid = v3_reg;
    assign out_cmd   = cmd3_reg;
    assign val_re    = re_reg;
    assign val_im    = im_reg;
    assign den       = den_reg;

endmodule

// ===== rtl/core/cau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for one result
// part. Depends on cau_pkg.

module cau_div
    import cau_pkg::*;
(
    input  logic              clk,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic              neg_in,
    input  logic              big_in,
    output logic [QUO_W-1:0]  quo,
    output logic              neg,
    output logic              big
);

    logic [NUM_W-1:0] rem_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic             neg_reg [0:QUO_W];
    logic             big_reg [0:QUO_W];

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num_in;
        den_reg[0] <= den_in;
        quo_reg[0] <= '0;
        neg_reg[0] <= neg_in;
        big_reg[0] <= big_in;
    end

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        localparam int SH = QUO_W - 1 - i;
        logic [CMP_W-1:0] dsh;
        logic [CMP_W-1:0] rext;
        logic [CMP_W-1:0] diff;
        logic             ge;

        assign dsh  = CMP_W'(den_reg[i]) << SH;
        assign rext = CMP_W'(rem_reg[i]);
        assign diff = rext - dsh;
        assign ge   = rext >= dsh;

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= ge ? diff[NUM_W-1:0] : rem_reg[i];
            den_reg[i+1] <= den_reg[i];
            quo_reg[i+1] <= quo_reg[i] | (QUO_W'(ge) << SH);
            neg_reg[i+1] <= neg_reg[i];
            big_reg[i+1] <= big_reg[i];
        end
    end

    assign quo = quo_reg[QUO_W];
    assign neg = neg_reg[QUO_W];
    assign big = big_reg[QUO_W];

endmodule

// ===== rtl/core/complex_arith_unit.sv =====
// Top level of the complex arithmetic unit: add, subtract, multiply, divide
// on signed Q16.16 complex operands. Depends on cau_pkg, cau_mult, cau_div.
//
// Usage:
//   Command channel: a beat is taken at each rising edge with start high and
//   busy low. busy is always low, so a new beat may enter on every cycle.
//   Result channel: done is high for one cycle with res_real, res_imag,
//   overflow and div_zero; the receiver must take the beat in that cycle.
//   The depth from the accepting edge to the cycle in which done is high is
//   the same for every command. Throughput: one beat per cycle.
//   The depth is set by the divider, which resolves one quotient bit per
//   stage over 32 stages, after an input, a product, a sum and a prepare
//   stage and a divider load stage, followed by the output register.
//   Add, subtract and multiply results ride a delay line alongside.
//   Results saturate and raise overflow. A divide by zero returns zero with
//   div_zero set.
//   Reset clears every valid bit; beats in flight are dropped and done stays
//   low until a new beat has passed through the pipeline.

module complex_arith_unit
    import cau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  cmd_t                     cmd,
    input  logic signed [DATA_W-1:0] a_real,
    input  logic signed [DATA_W-1:0] a_imag,
    input  logic signed [DATA_W-1:0] b_real,
    input  logic signed [DATA_W-1:0] b_imag,
    output logic                     done,
    output logic signed [DATA_W-1:0] res_real,
    output logic signed [DATA_W-1:0] res_imag,
    output logic                     overflow,
    output logic                     div_zero
);

    typedef struct packed {
        logic              is_div;
        logic              dz;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              ovf;
    } byp_t;

    logic                    acc;
    logic                    v3;
    cmd_t                    cmd3;
    logic signed [SUM_W-1:0] val_re, val_im;
    logic [DEN_W-1:0]        den;

    logic signed [SUM_W-1:0] sh_re, sh_im;
    sat_t                    s_re, s_im;
    logic [MAG_W-1:0]        mag_re, mag_im;
    logic [NUM_W-1:0]        num_re, num_im;
    logic [CMP_W-1:0]        den_top;

    logic                    v4_reg;
    byp_t                    byp4_reg, byp4_next;
    logic [NUM_W-1:0]        num_re_reg, num_im_reg;
    logic [DEN_W-1:0]        den4_reg;
    logic                    neg_re_reg, neg_im_reg, big_re_reg, big_im_reg;
    logic                    big_re_next, big_im_next;

    logic                    vd_reg  [0:DIV_LAT-1];
    byp_t                    bypd_reg [0:DIV_LAT-1];

    logic [QUO_W-1:0]        q_re, q_im;
    logic                    qn_re, qn_im, qb_re, qb_im;
    sat_t                    f_re, f_im;

    logic                    done_reg;
    logic [DATA_W-1:0]       re_reg, im_reg, re_next, im_next;
    logic                    ovf_reg, dz_reg, ovf_next, dz_next;

    assign busy = 1'b0;
    assign acc  = start && !busy;

    cau_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc),
        .cmd       (cmd),
        .a_real    (a_real),
        .a_imag    (a_imag),
        .b_real    (b_real),
        .b_imag    (b_imag),
        .out_valid (v3),
        .out_cmd   (cmd3),
        .val_re    (val_re),
        .val_im    (val_im),
        .den       (den)
    );

    // multiply: drop fraction bits, rounding toward zero
    assign sh_re = (val_re + (val_re[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0))) >>> FRAC_W;
    assign sh_im = (val_im + (val_im[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0))) >>> FRAC_W;
    assign s_re  = sat_sum((cmd3 == CMD_MUL) ? sh_re : val_re);
    assign s_im  = sat_sum((cmd3 == CMD_MUL) ? sh_im : val_im);

    assign mag_re  = val_re[SUM_W-1] ? MAG_W'(-val_re) : MAG_W'(val_re);
    assign mag_im  = val_im[SUM_W-1] ? MAG_W'(-val_im) : MAG_W'(val_im);
    assign num_re  = {mag_re, {FRAC_W{1'b0}}};
    assign num_im  = {mag_im, {FRAC_W{1'b0}}};
    assign den_top = {1'b0, den, {QUO_W{1'b0}}};
    assign big_re_next = CMP_W'(num_re) >= den_top;
    assign big_im_next = CMP_W'(num_im) >= den_top;

    always_comb
    begin
        byp4_next.is_div = (cmd3 == CMD_DIV);
        byp4_next.dz     = (cmd3 == CMD_DIV) && (den == '0);
        byp4_next.re     = s_re.val;
        byp4_next.im     = s_im.val;
        byp4_next.ovf    = s_re.ovf || s_im.ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3;
        end
    end

    always_ff @(posedge clk)
    begin
        byp4_reg   <= byp4_next;
        num_re_reg <= num_re;
        num_im_reg <= num_im;
        den4_reg   <= den;
        neg_re_reg <= val_re[SUM_W-1];
        neg_im_reg <= val_im[SUM_W-1];
        big_re_reg <= big_re_next;
        big_im_reg <= big_im_next;
    end

    cau_div u_div_re (
        .clk    (clk),
        .num_in (num_re_reg),
        .den_in (den4_reg),
        .neg_in (neg_re_reg),
        .big_in (big_re_reg),
        .quo    (q_re),
        .neg    (qn_re),
        .big    (qb_re)
    );

    cau_div u_div_im (
        .clk    (clk),
        .num_in (num_im_reg),
        .den_in (den4_reg),
        .neg_in (neg_im_reg),
        .big_in (big_im_reg),
        .quo    (q_im),
        .neg    (qn_im),
        .big    (qb_im)
    );

    for (genvar j = 0; j < DIV_LAT; j++)
    begin : g_dly
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[j] <= 1'b0;
            end
            else
            begin
                vd_reg[j] <= (j == 0) ? v4_reg : vd_reg[(j == 0) ? 0 : j - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            bypd_reg[j] <= (j == 0) ? byp4_reg : bypd_reg[(j == 0) ? 0 : j - 1];
        end
    end

    assign f_re = sat_quo(q_re, qn_re, qb_re);
    assign f_im = sat_quo(q_im, qn_im, qb_im);

    always_comb
    begin
        priority if (bypd_reg[DIV_LAT-1].dz)
        begin
            re_next  = '0;
            im_next  = '0;
            ovf_next = 1'b0;
            dz_next  = 1'b1;
        end
        else if (bypd_reg[DIV_LAT-1].is_div)
        begin
            re_next  = f_re.val;
            im_next  = f_im.val;
            ovf_next = f_re.ovf || f_im.ovf;
            dz_next  = 1'b0;
        end
        else
        begin
            re_next  = bypd_reg[DIV_LAT-1].re;
            im_next  = bypd_reg[DIV_LAT-1].im;
            ovf_next = bypd_reg[DIV_LAT-1].ovf;
            dz_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vd_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg  <= re_next;
        im_reg  <= im_next;
        ovf_reg <= ovf_next;
        dz_reg  <= dz_next;
    end

    assign done     = done_reg;
    assign res_real = re_reg;
    assign res_imag = im_reg;
    assign overflow = ovf_reg;
    assign div_zero = dz_reg;

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && div_zero |-> !overflow && res_real == '0 && res_imag == '0)
        else $error("divide by zero beat carries nonzero data");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |-> res_real == SAT_MAX || res_real == SAT_MIN ||
                             res_imag == SAT_MAX || res_imag == SAT_MIN)
        else $error("overflow without a saturated part");

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LAT + 1))
        else $error("result beat without a command beat");

endmodule

// ===== dv/tb.sv =====
// Testbench for complex_arith_unit: random and directed complex add, sub, mul, div
// beats checked against an exact in-bench predictor. Depends on cau_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
    import cau_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              ovf;
        logic              dz;
    } cres_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic signed [DATA_W-1:0] a_real, a_imag, b_real, b_imag;
    logic done;
    logic signed [DATA_W-1:0] res_real, res_imag;
    logic overflow, div_zero;

    cres_t pending[$];
    int    n_err;
    int    idle_pct;
    int    quiet;

    complex_arith_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
        .done(done), .res_real(res_real), .res_imag(res_imag),
        .overflow(overflow), .div_zero(div_zero)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // saturate an exact signed value into DATA_W bits
    function automatic logic [DATA_W-1:0] clamp(input logic signed [127:0] x,
                                                inout logic ovf);
        if (x > 128'sd2147483647)
        begin
            ovf = 1'b1;
            return SAT_MAX;
        end
        if (x < -128'sd2147483648)
        begin
            ovf = 1'b1;
            return SAT_MIN;
        end
        return x[DATA_W-1:0];
    endfunction

    // truncating division on exact values
    function automatic logic signed [127:0] tdiv(input logic signed [127:0] n,
                                                 input logic signed [127:0] d);
        logic [127:0] nm, dm, q;
        nm = n < 0 ? -n : n;
        dm = d < 0 ? -d : d;
        q  = nm / dm;
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic cres_t complex_op(input cmd_t c,
                                         input logic signed [DATA_W-1:0] ar, ai, br, bi);
        cres_t r;
        logic signed [127:0] xr, xi, yr, yi, sr, si, den;
        xr = ar;
        xi = ai;
        yr = br;
        yi = bi;
        r.ovf = 1'b0;
        r.dz  = 1'b0;
        sr = 0;
        si = 0;
        case (c)
            CMD_ADD:
            begin
                sr = xr + yr;
                si = xi + yi;
            end
            CMD_SUB:
            begin
                sr = xr - yr;
                si = xi - yi;
            end
            CMD_MUL:
            begin
                sr = tdiv(xr * yr - xi * yi, 128'sd65536);
                si = tdiv(xr * yi + xi * yr, 128'sd65536);
            end
            default:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    sr = tdiv((xr * yr + xi * yi) * 128'sd65536, den);
                    si = tdiv((xi * yr - xr * yi) * 128'sd65536, den);
                end
            end
        endcase
        r.re = clamp(sr, r.ovf);
        r.im = clamp(si, r.ovf);
        return r;
    endfunction

    task automatic send_beat(input cmd_t c, input logic [DATA_W-1:0] ar, ai, br, bi);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        cmd    <= c;
        a_real <= ar;
        a_imag <= ai;
        b_real <= br;
        b_imag <= bi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending.push_back(complex_op(c, ar, ai, br, bi));
    endtask

    function automatic logic [DATA_W-1:0] rand_part();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? SAT_MAX : SAT_MIN;
            1: return $urandom_range(200) - 100;
            2: return $signed($urandom_range(65535)) - 32768 <<< $urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [DATA_W-1:0] v[6];
        v = '{SAT_MAX, SAT_MIN, 0, 32'h0001_0000, 32'hFFFF_0000, 1};
        for (int c = 0; c < 4; c++)
            for (int k = 0; k < 6; k++)
                send_beat(cmd_t'(c), v[k], v[5-k], v[(k+2)%6], v[(k+4)%6]);
        send_beat(CMD_DIV, 32'h0003_0000, 32'h0004_0000, 0, 0);
    endtask

    task automatic test_random(input int count, input int pct);
        idle_pct = pct;
        repeat (count)
            send_beat(cmd_t'($urandom_range(3)), rand_part(), rand_part(),
                      rand_part(), rand_part());
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending.size() == 0)
            begin
                $error("result with no beat outstanding");
                n_err++;
            end
            else
            begin
                cres_t e;
                e = pending.pop_front();
                if (res_real !== e.re)
                begin
                    $error("res_real exp %0d got %0d", $signed(e.re), res_real);
                    n_err++;
                end
                if (res_imag !== e.im)
                begin
                    $error("res_imag exp %0d got %0d", $signed(e.im), res_imag);
                    n_err++;
                end
                if (overflow !== e.ovf)
                begin
                    $error("overflow exp %0b got %0b", e.ovf, overflow);
                    n_err++;
                end
                if (div_zero !== e.dz)
                begin
                    $error("div_zero exp %0b got %0b", e.dz, div_zero);
                    n_err++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 2000)
        begin
            $display("[complex_arith_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        n_err = 0;
        quiet = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_ADD;
        a_real = '0;
        a_imag = '0;
        b_real = '0;
        b_imag = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain();
        test_random(550, 28);
        drain();
        test_random(550, 63);
        test_random(550, 0);
        drain();
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (n_err == 0)
            $display("[complex_arith_unit] OK");
        else
            $display("[complex_arith_unit] ERROR");
        $finish;
    end
endmodule
